@@ design/spline_garch_variance_recursion_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Spline GARCH variance unit: assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SPLINE_GARCH_VARIANCE_RECURSION_UNIT_DEFINES_SVH
`define SPLINE_GARCH_VARIANCE_RECURSION_UNIT_DEFINES_SVH

// condition implies consequence in the same cycle
`define SGV_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed");

// condition implies consequence in the next cycle
`define SGV_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed");

`endif

@@ design/sgv_pkg.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance package
// Widths, codes and saturating helpers shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgv_pkg;

   localparam int WORD_W    = 48;
   localparam int MAX_KNOTS = 16;
   localparam int FRAC_BITS = 32;

   localparam logic signed [WORD_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [WORD_W-1:0] NEG_MIN = 48'sh8000_0000_0000;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_START  = 2'd1;
   localparam logic [1:0] CMD_RETURN = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NONPOS  = 2'd1;
   localparam logic [1:0] STAT_REFUSED = 2'd2;
   localparam logic [1:0] STAT_LOADED  = 2'd3;

   localparam logic [2:0] REG_INIT_VAR = 3'd0;
   localparam logic [2:0] REG_OMEGA    = 3'd1;
   localparam logic [2:0] REG_C0       = 3'd2;
   localparam logic [2:0] REG_C1       = 3'd3;
   localparam logic [2:0] REG_C2       = 3'd4;
   localparam logic [2:0] REG_KNOTS    = 3'd5;

   function automatic logic signed [WORD_W-1:0] add_sat(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} + {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         add_sat = s[WORD_W] ? NEG_MIN : POS_MAX;
      end else begin
         add_sat = s[WORD_W-1:0];
      end
   endfunction

   function automatic logic signed [WORD_W-1:0] sub_sat(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
      logic signed [WORD_W:0] s;
      s = {a[WORD_W-1], a} - {b[WORD_W-1], b};
      if (s[WORD_W] != s[WORD_W-1]) begin
         sub_sat = s[WORD_W] ? NEG_MIN : POS_MAX;
      end else begin
         sub_sat = s[WORD_W-1:0];
      end
   endfunction

endpackage

@@ design/sgv_ifs.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sgv_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic [3:0]         knot_index;
   logic signed [47:0] knot_position;
   logic signed [47:0] knot_weight;
   logic signed [47:0] return_value;
   modport source (output valid, command, knot_index, knot_position, knot_weight,
                   return_value, input ready);
   modport sink (input valid, command, knot_index, knot_position, knot_weight,
                 return_value, output ready);
endinterface

interface sgv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] variance;
   logic signed [47:0] standardized_return;
   logic [1:0]         status;
   modport source (output valid, variance, standardized_return, status, input ready);
   modport sink (input valid, variance, standardized_return, status, output ready);
endinterface

interface sgv_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/sgv_ram.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sgv_mul.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance multiplier
// Fixed-point product over three 48x16 partial steps, magnitude truncated,
// saturated to 48 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgv_mul #(
   parameter int FRAC_BITS = sgv_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] a,
   input  logic signed [47:0] b,
   output logic               done,
   output logic signed [47:0] p
);

   logic [47:0]        mag_a_ff, mag_a_in;
   logic [47:0]        mag_b_ff, mag_b_in;
   logic               neg_ff, neg_in;
   logic [95:0]        acc_ff, acc_in;
   logic [1:0]         k_ff, k_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [47:0] p_ff, p_in;
   logic [15:0]        chunk;
   logic [63:0]        pp;
   logic [95:0]        shv;

   always_comb begin
      mag_a_in = mag_a_ff;
      mag_b_in = mag_b_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      k_in     = k_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      p_in     = p_ff;
      chunk    = mag_b_ff[16*k_ff +: 16];
      pp       = 64'(mag_a_ff) * 64'(chunk);
      shv      = '0;
      if (start) begin
         mag_a_in = a[47] ? 48'(-a) : 48'(a);
         mag_b_in = b[47] ? 48'(-b) : 48'(b);
         neg_in   = a[47] ^ b[47];
         acc_in   = '0;
         k_in     = 2'd0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (96'(pp) << (16 * k_ff));
         k_in   = k_ff + 2'd1;
         if (k_ff == 2'd2) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            shv     = acc_in >> FRAC_BITS;
            if (neg_ff) begin
               p_in = (shv > 96'h8000_0000_0000) ? sgv_pkg::NEG_MIN : -$signed(shv[47:0]);
            end else begin
               p_in = (shv > 96'(sgv_pkg::POS_MAX)) ? sgv_pkg::POS_MAX : $signed(shv[47:0]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
      k_ff     <= k_in;
      p_ff     <= p_in;
   end

   assign done = done_ff;
   assign p    = p_ff;

endmodule

@@ design/sgv_sqdiv.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance root and divide unit
// Bit-serial square root of the variance, then restoring division of the
// return by that root, saturated to 48 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgv_sqdiv #(
   parameter int FRAC_BITS = sgv_pkg::FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [47:0] variance_in,
   input  logic signed [47:0] return_in,
   output logic               done,
   output logic signed [47:0] e_out
);

   localparam int RW   = (48 + FRAC_BITS + 1) / 2;
   localparam int RADW = 2 * RW;
   localparam int NB   = 48 + FRAC_BITS;
   localparam int SRW  = RW + 3;
   localparam int DRW  = RW + 1;
   localparam int CNTW = $clog2(NB + 1);
   localparam int QW   = 49;

   typedef enum logic [2:0] {
      SD_IDLE = 3'b001,
      SD_ROOT = 3'b010,
      SD_DIV  = 3'b100
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [CNTW-1:0]    cnt_ff, cnt_in;
   logic [RADW-1:0]    rad_ff, rad_in;
   logic [SRW-1:0]     srem_ff, srem_in;
   logic [RW-1:0]      root_ff, root_in;
   logic [NB-1:0]      num_ff, num_in;
   logic [DRW-1:0]     drem_ff, drem_in;
   logic [QW-1:0]      q_ff, q_in;
   logic               ovf_ff, ovf_in;
   logic               neg_ff, neg_in;
   logic               done_ff, done_in;
   logic signed [47:0] e_ff, e_in;
   logic [SRW-1:0]     srem_sh, trial;
   logic [DRW-1:0]     drem_sh, dvs;
   logic [47:0]        mag_r;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      q_in     = q_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      e_in     = e_ff;
      mag_r    = return_in[47] ? 48'(-return_in) : 48'(return_in);
      srem_sh  = {srem_ff[SRW-3:0], rad_ff[RADW-1:RADW-2]};
      trial    = SRW'({root_ff, 2'b01});
      drem_sh  = {drem_ff[DRW-2:0], num_ff[NB-1]};
      dvs      = DRW'(root_ff);
      case (phase_ff)
         SD_IDLE: begin
            if (start) begin
               rad_in   = RADW'({48'(variance_in), {FRAC_BITS{1'b0}}});
               num_in   = {mag_r, {FRAC_BITS{1'b0}}};
               neg_in   = return_in[47];
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               phase_in = SD_ROOT;
            end
         end
         SD_ROOT: begin
            rad_in = rad_ff << 2;
            if (srem_sh >= trial) begin
               srem_in = srem_sh - trial;
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               srem_in = srem_sh;
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(RW - 1)) begin
               cnt_in   = '0;
               drem_in  = '0;
               q_in     = '0;
               ovf_in   = 1'b0;
               phase_in = SD_DIV;
            end
         end
         SD_DIV: begin
            num_in = num_ff << 1;
            ovf_in = ovf_ff | q_ff[QW-1];
            if (drem_sh >= dvs) begin
               drem_in = drem_sh - dvs;
               q_in    = {q_ff[QW-2:0], 1'b1};
            end else begin
               drem_in = drem_sh;
               q_in    = {q_ff[QW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(NB - 1)) begin
               phase_in = SD_IDLE;
               done_in  = 1'b1;
               if (neg_ff) begin
                  e_in = (ovf_in || q_in > 49'h0_8000_0000_0000) ? sgv_pkg::NEG_MIN
                                                                 : -$signed(q_in[47:0]);
               end else begin
                  e_in = (ovf_in || q_in > 49'(sgv_pkg::POS_MAX)) ? sgv_pkg::POS_MAX
                                                                  : $signed(q_in[47:0]);
               end
            end
         end
         default: phase_in = SD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= SD_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
      rad_ff  <= rad_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      num_ff  <= num_in;
      drem_ff <= drem_in;
      q_ff    <= q_in;
      ovf_ff  <= ovf_in;
      neg_ff  <= neg_in;
      e_ff    <= e_in;
   end

   assign done  = done_ff;
   assign e_out = e_ff;

endmodule

@@ design/spline_garch_variance_recursion_unit.sv @@
// Load, start and refused commands: accepted in idle, result word next cycle; unknown commands give no word.
// Return: from accept to result word, the bit-serial root/divide unit runs, then the
// shared three-step multiplier does M multiplies (M = 4 plus 2 per knot hit), with a
// knot RAM read and test for each of the K knots in use; one item at a time.
// Reset: registers to defaults, variance zero, series failed; knot table undefined
// until loaded.
// ----------------------------------------------------------------------------
// Spline GARCH variance recursion unit
// Sequencer around a shared root/divide unit, multiplier and knot RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spline_garch_variance_recursion_unit #(
   parameter int MAX_KNOTS = sgv_pkg::MAX_KNOTS,
   parameter int FRAC_BITS = sgv_pkg::FRAC_BITS
) (
   input logic      clock,
   input logic      reset,
   sgv_req_if.sink  req_port,
   sgv_rsp_if.source rsp_port,
   sgv_csr_if.sink  csr_port
);

   localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
   localparam int CW = $clog2(MAX_KNOTS + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_ROOT  = 5'b00010,
      S_MUL   = 5'b00100,
      S_KREAD = 5'b01000,
      S_KTEST = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      OP_LIN = 3'd0,
      OP_SQ1 = 3'd1,
      OP_SQ2 = 3'd2,
      OP_KD  = 3'd3,
      OP_KW  = 3'd4,
      OP_VAR = 3'd5
   } op_type;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic signed [47:0] init_ff, omega_ff, c0_ff, c1_ff, c2_ff;
   logic [4:0]         kiu_ff;
   logic signed [47:0] cur_var_ff, cur_var_in;
   logic               failed_ff, failed_in;
   logic signed [47:0] e_ff, e_in;
   logic signed [47:0] t_ff, t_in;
   logic [CW-1:0]      j_ff, j_in;
   logic [CW-1:0]      n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_var_ff, rsp_var_in;
   logic signed [47:0] rsp_e_ff, rsp_e_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               req_fire;
   logic               idx_ok;
   logic               ram_we;
   logic [95:0]        ram_rd;
   logic signed [47:0] kpos, kw, diff, sum_a, add_res;
   logic               mul_start, mul_done, sd_start, sd_done;
   logic signed [47:0] mul_a, mul_b, mul_p, sd_e;

   assign req_fire     = req_port.valid & req_port.ready;
   assign req_port.ready = (state_ff == S_IDLE) & ~rsp_valid_ff;
   assign csr_port.ready = 1'b1;
   assign idx_ok       = 32'(req_port.knot_index) < MAX_KNOTS;
   assign kpos         = ram_rd[95:48];
   assign kw           = ram_rd[47:0];
   assign diff         = sgv_pkg::sub_sat(e_ff, kpos);
   assign sum_a        = (op_ff == OP_VAR) ? omega_ff : t_ff;
   assign add_res      = sgv_pkg::add_sat(sum_a, mul_p);

   sgv_ram #(.WIDTH(96), .DEPTH(MAX_KNOTS)) u_knots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_port.knot_index)),
      .wr_data ({req_port.knot_position, req_port.knot_weight}),
      .rd_addr (j_ff[AW-1:0]),
      .rd_data (ram_rd)
   );

   sgv_sqdiv #(.FRAC_BITS(FRAC_BITS)) u_sqdiv (
      .clock       (clock),
      .reset       (reset),
      .start       (sd_start),
      .variance_in (cur_var_ff),
      .return_in   (req_port.return_value),
      .done        (sd_done),
      .e_out       (sd_e)
   );

   sgv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cur_var_in    = cur_var_ff;
      failed_in     = failed_ff;
      e_in          = e_ff;
      t_in          = t_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_port.ready;
      rsp_var_in    = rsp_var_ff;
      rsp_e_in      = rsp_e_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      sd_start      = 1'b0;
      mul_start     = 1'b0;
      mul_a         = e_ff;
      mul_b         = e_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_port.command)
                  sgv_pkg::CMD_LOAD: begin
                     ram_we        = idx_ok;
                     rsp_valid_in  = 1'b1;
                     rsp_var_in    = '0;
                     rsp_e_in      = '0;
                     rsp_status_in = sgv_pkg::STAT_LOADED;
                  end
                  sgv_pkg::CMD_START: begin
                     cur_var_in    = init_ff;
                     failed_in     = init_ff[47] | (init_ff == '0);
                     rsp_valid_in  = 1'b1;
                     rsp_var_in    = init_ff;
                     rsp_e_in      = '0;
                     rsp_status_in = (init_ff[47] | (init_ff == '0)) ? sgv_pkg::STAT_NONPOS
                                                                     : sgv_pkg::STAT_OK;
                  end
                  sgv_pkg::CMD_RETURN: begin
                     if (failed_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_var_in    = '0;
                        rsp_e_in      = '0;
                        rsp_status_in = sgv_pkg::STAT_REFUSED;
                     end else begin
                        sd_start = 1'b1;
                        n_in     = (32'(kiu_ff) > MAX_KNOTS) ? CW'(MAX_KNOTS) : CW'(kiu_ff);
                        state_in = S_ROOT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_ROOT: begin
            if (sd_done) begin
               e_in      = sd_e;
               t_in      = c0_ff;
               mul_start = 1'b1;
               mul_a     = c1_ff;
               mul_b     = sd_e;
               op_in     = OP_LIN;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (mul_done) begin
               case (op_ff)
                  OP_LIN: begin
                     t_in      = add_res;
                     mul_start = 1'b1;
                     op_in     = OP_SQ1;
                  end
                  OP_SQ1: begin
                     mul_start = 1'b1;
                     mul_a     = c2_ff;
                     mul_b     = mul_p;
                     op_in     = OP_SQ2;
                  end
                  OP_SQ2, OP_KW: begin
                     t_in = add_res;
                     if ((op_ff == OP_SQ2 && n_ff == '0) ||
                         (op_ff == OP_KW && (j_ff + CW'(1)) == n_ff)) begin
                        mul_start = 1'b1;
                        mul_a     = cur_var_ff;
                        mul_b     = add_res;
                        op_in     = OP_VAR;
                     end else begin
                        j_in     = (op_ff == OP_SQ2) ? '0 : j_ff + CW'(1);
                        state_in = S_KREAD;
                     end
                  end
                  OP_KD: begin
                     mul_start = 1'b1;
                     mul_a     = kw;
                     mul_b     = mul_p;
                     op_in     = OP_KW;
                  end
                  OP_VAR: begin
                     cur_var_in    = add_res;
                     failed_in     = add_res[47] | (add_res == '0);
                     rsp_valid_in  = 1'b1;
                     rsp_var_in    = add_res;
                     rsp_e_in      = e_ff;
                     rsp_status_in = (add_res[47] | (add_res == '0)) ? sgv_pkg::STAT_NONPOS
                                                                     : sgv_pkg::STAT_OK;
                     state_in      = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_KREAD: state_in = S_KTEST;
         S_KTEST: begin
            if (e_ff >= kpos) begin
               mul_start = 1'b1;
               mul_a     = diff;
               mul_b     = diff;
               op_in     = OP_KD;
               state_in  = S_MUL;
            end else if ((j_ff + CW'(1)) == n_ff) begin
               mul_start = 1'b1;
               mul_a     = cur_var_ff;
               mul_b     = t_ff;
               op_in     = OP_VAR;
               state_in  = S_MUL;
            end else begin
               j_in     = j_ff + CW'(1);
               state_in = S_KREAD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_LIN;
         init_ff      <= 48'sd1 <<< FRAC_BITS;
         omega_ff     <= '0;
         c0_ff        <= '0;
         c1_ff        <= '0;
         c2_ff        <= '0;
         kiu_ff       <= '0;
         cur_var_ff   <= '0;
         failed_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
         j_ff         <= '0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cur_var_ff   <= cur_var_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         if (csr_port.valid) begin
            case (csr_port.index)
               sgv_pkg::REG_INIT_VAR: init_ff  <= $signed(csr_port.data);
               sgv_pkg::REG_OMEGA:    omega_ff <= $signed(csr_port.data);
               sgv_pkg::REG_C0:       c0_ff    <= $signed(csr_port.data);
               sgv_pkg::REG_C1:       c1_ff    <= $signed(csr_port.data);
               sgv_pkg::REG_C2:       c2_ff    <= $signed(csr_port.data);
               sgv_pkg::REG_KNOTS:    kiu_ff   <= csr_port.data[4:0];
               default: ;
            endcase
         end
      end
      e_ff          <= e_in;
      t_ff          <= t_in;
      rsp_var_ff    <= rsp_var_in;
      rsp_e_ff      <= rsp_e_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_port.valid               = rsp_valid_ff;
   assign rsp_port.variance            = rsp_var_ff;
   assign rsp_port.standardized_return = rsp_e_ff;
   assign rsp_port.status              = rsp_status_ff;

endmodule

@@ design/sgv_checker.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance port checker
// Port-level checks on the handshakes and result words, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "spline_garch_variance_recursion_unit_defines.svh"

module sgv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_command,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] rsp_variance,
   input logic [47:0] rsp_std,
   input logic [1:0]  rsp_status
);

   `SGV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SGV_ASSERT_NOW(a_busy_with_word, clock, reset, rsp_valid, !req_ready)
   `SGV_ASSERT_NEXT(a_busy_after_cmd, clock, reset, req_valid && req_ready && req_command <= sgv_pkg::CMD_RETURN, !req_ready)
   `SGV_ASSERT_NOW(a_load_word_zero, clock, reset, rsp_valid && rsp_status == sgv_pkg::STAT_LOADED, rsp_variance == 48'd0 && rsp_std == 48'd0)

endmodule

bind spline_garch_variance_recursion_unit sgv_checker u_sgv_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .req_command  (req_port.command),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .rsp_variance (rsp_port.variance),
   .rsp_std      (rsp_port.standardized_return),
   .rsp_status   (rsp_port.status)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Spline GARCH variance recursion unit testbench
// Drives load, start, return and unused commands with random gaps. A local
// fixed-point predictor tracks variance, knots and the fail state, and each
// response word is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 3000000;
   localparam int         SETTLE_CYCLES = 400;
   localparam longint     ONE_Q = 64'sd1 << sgv_pkg::FRAC_BITS;
   localparam longint     POS_Q = 64'sh7FFF_FFFF_FFFF;
   localparam longint     NEG_Q = -(64'sd1 <<< 47);

   typedef struct packed {
      logic [47:0] variance;
      logic [47:0] std_return;
      logic [1:0]  status;
   } variance_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sgv_req_if req_if ();
   sgv_rsp_if rsp_if ();
   sgv_csr_if csr_if ();

   spline_garch_variance_recursion_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if.sink),
      .rsp_port (rsp_if.source),
      .csr_port (csr_if.sink)
   );

   always #5 clock = ~clock;

   // predictor state
   longint init_var_q, omega_q, c0_q, c1_q, c2_q;
   int unsigned knots_used;
   longint      cur_var;
   bit          series_down;
   longint      knot_pos [sgv_pkg::MAX_KNOTS];
   longint      knot_wt [sgv_pkg::MAX_KNOTS];

   variance_word_type pending_words[$];
   int  mismatches = 0;
   int  cycle_count = 0;
   bit  req_gaps_on = 1'b1;
   bit  rsp_stalls_on = 1'b1;
   int  stall_left = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic longint clamp48(longint x);
      if (x > POS_Q) return POS_Q;
      if (x < NEG_Q) return NEG_Q;
      return x;
   endfunction

   function automatic logic [63:0] mag64(longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint sat_magnitude(logic [127:0] m, bit neg);
      if (neg) begin
         if (m > 128'h8000_0000_0000) return NEG_Q;
         return -longint'(m[63:0]);
      end
      if (m > 128'h7FFF_FFFF_FFFF) return POS_Q;
      return longint'(m[63:0]);
   endfunction

   function automatic longint fixed_mul(longint a, longint b);
      logic [127:0] p;
      p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
      return sat_magnitude(p >> sgv_pkg::FRAC_BITS, (a < 0) != (b < 0));
   endfunction

   function automatic logic [63:0] wide_root(logic [127:0] n);
      logic [63:0] r;
      logic [63:0] c;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= n) r = c;
      end
      return r;
   endfunction

   // work out the response word, if any, for one accepted request
   task automatic predict_variance_step(logic [1:0] cmd, logic [3:0] idx,
                                        logic signed [47:0] pos, logic signed [47:0] wt,
                                        logic signed [47:0] ret);
      variance_word_type w;
      longint r, e, t, nv, d;
      logic [63:0] root;
      int unsigned n;
      w = '0;
      e = 0;
      case (cmd)
         sgv_pkg::CMD_LOAD: begin
            knot_pos[idx] = longint'(pos);
            knot_wt[idx] = longint'(wt);
            w.status = sgv_pkg::STAT_LOADED;
         end
         sgv_pkg::CMD_START: begin
            cur_var = init_var_q;
            series_down = (cur_var <= 0);
            w.variance = cur_var[47:0];
            w.status = series_down ? sgv_pkg::STAT_NONPOS : sgv_pkg::STAT_OK;
         end
         sgv_pkg::CMD_RETURN: begin
            if (series_down) begin
               w.status = sgv_pkg::STAT_REFUSED;
            end else begin
               r = longint'(ret);
               root = wide_root({64'd0, 64'(cur_var)} << sgv_pkg::FRAC_BITS);
               e = sat_magnitude(({64'd0, mag64(r)} << sgv_pkg::FRAC_BITS) / {64'd0, root},
                                 r < 0);
               t = c0_q;
               t = clamp48(t + fixed_mul(c1_q, e));
               t = clamp48(t + fixed_mul(c2_q, fixed_mul(e, e)));
               n = (knots_used > sgv_pkg::MAX_KNOTS) ? sgv_pkg::MAX_KNOTS : knots_used;
               for (int j = 0; j < n; j++) begin
                  if (e >= knot_pos[j]) begin
                     d = clamp48(e - knot_pos[j]);
                     t = clamp48(t + fixed_mul(knot_wt[j], fixed_mul(d, d)));
                  end
               end
               nv = clamp48(omega_q + fixed_mul(cur_var, t));
               cur_var = nv;
               w.variance = nv[47:0];
               w.std_return = e[47:0];
               if (nv <= 0) begin
                  series_down = 1'b1;
                  w.status = sgv_pkg::STAT_NONPOS;
               end
            end
         end
         default: return;
      endcase
      pending_words.push_back(w);
   endtask

   // response side: random stalls, check each word
   always @(posedge clock) begin
      variance_word_type want;
      int stall;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_if.valid && rsp_if.ready) begin
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: var %h e %h st %0d",
               rsp_if.variance, rsp_if.standardized_return, rsp_if.status);
         end else begin
            want = pending_words.pop_front();
            if (rsp_if.variance !== want.variance ||
                rsp_if.standardized_return !== want.std_return ||
                rsp_if.status !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp var %h e %h st %0d, got var %h e %h st %0d",
                     want.variance, want.std_return, want.status, rsp_if.variance,
                     rsp_if.standardized_return, rsp_if.status);
            end
         end
         stall = rsp_stalls_on ? $urandom_range(0, 11) : 0;
         rsp_if.ready <= (stall == 0);
         stall_left <= stall;
      end else if (!rsp_if.ready) begin
         if (stall_left <= 1) rsp_if.ready <= 1'b1;
         else stall_left <= stall_left - 1;
      end
   end

   task automatic send_word(logic [1:0] cmd, logic [3:0] idx, logic [47:0] pos,
                            logic [47:0] wt, logic [47:0] ret);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.command <= cmd;
      req_if.knot_index <= idx;
      req_if.knot_position <= pos;
      req_if.knot_weight <= wt;
      req_if.return_value <= ret;
      do @(posedge clock); while (!req_if.ready);
      predict_variance_step(cmd, idx, pos, wt, ret);
   endtask

   task automatic write_register(logic [2:0] index, logic [47:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (index)
         sgv_pkg::REG_INIT_VAR: init_var_q = longint'($signed(data));
         sgv_pkg::REG_OMEGA:    omega_q = longint'($signed(data));
         sgv_pkg::REG_C0:       c0_q = longint'($signed(data));
         sgv_pkg::REG_C1:       c1_q = longint'($signed(data));
         sgv_pkg::REG_C2:       c2_q = longint'($signed(data));
         sgv_pkg::REG_KNOTS:    knots_used = data[4:0];
         default: ;
      endcase
   endtask

   task automatic configure(longint iv, longint om, longint k0, longint k1, longint k2,
                            int unsigned nk);
      write_register(sgv_pkg::REG_INIT_VAR, iv[47:0]);
      write_register(sgv_pkg::REG_OMEGA, om[47:0]);
      write_register(sgv_pkg::REG_C0, k0[47:0]);
      write_register(sgv_pkg::REG_C1, k1[47:0]);
      write_register(sgv_pkg::REG_C2, k2[47:0]);
      write_register(sgv_pkg::REG_KNOTS, 48'(nk));
      csr_if.valid <= 1'b0;
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic longint rand_sym(int unsigned half);
      return longint'($urandom_range(0, half)) - longint'($urandom_range(0, half));
   endfunction

   function automatic logic [47:0] rand48();
      return 48'({$urandom, $urandom});
   endfunction

   task automatic test_refused_before_start();
      send_word(sgv_pkg::CMD_RETURN, 4'd0, '0, '0, ONE_Q[47:0]);
      send_word(CMD_UNUSED, 4'hF, '1, '1, '1);
   endtask

   task automatic test_knot_table();
      for (int i = 0; i < sgv_pkg::MAX_KNOTS; i++)
         send_word(sgv_pkg::CMD_LOAD, 4'(i),
                   (i == 0) ? POS_Q[47:0] : (i == 1) ? NEG_Q[47:0] :
                   48'(rand_sym(32'hFFFF_FFFF) * 2), 48'(rand_sym(32'h0800_0000)), '0);
   endtask

   task automatic test_return_extremes();
      configure(ONE_Q, ONE_Q >> 4, ONE_Q / 2, ONE_Q / 8, ONE_Q / 16, sgv_pkg::MAX_KNOTS);
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, POS_Q[47:0]);
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, NEG_Q[47:0]);
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, '0);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, 48'h1);
      drain();
   endtask

   task automatic test_failing_series();
      configure(-ONE_Q, 0, 0, 0, 0, 0);
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, ONE_Q[47:0]);
      drain();
      configure(0, -ONE_Q, 0, 0, 0, 31);
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      drain();
      configure(ONE_Q, -ONE_Q, 0, 0, 0, 0);
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, ONE_Q[47:0]);
      send_word(sgv_pkg::CMD_RETURN, '0, '0, '0, ONE_Q[47:0]);
      drain();
   endtask

   task automatic test_random_series(bit wild, int count);
      int unsigned pick;
      longint ret;
      req_gaps_on = $urandom_range(0, 2) != 0;
      rsp_stalls_on = $urandom_range(0, 2) != 0;
      if (wild)
         configure(longint'($signed(rand48())), longint'($signed(rand48())),
                   longint'($signed(rand48())), longint'($signed(rand48())),
                   longint'($signed(rand48())), $urandom_range(0, 31));
      else
         configure(longint'($urandom_range(1, 16)) << 30, $urandom_range(0, 32'h1000_0000),
                   64'h8000_0000 + $urandom_range(0, 32'h6000_0000),
                   rand_sym(32'h1000_0000), $urandom_range(0, 32'h2000_0000),
                   $urandom_range(0, 31));
      send_word(sgv_pkg::CMD_START, '0, '0, '0, '0);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_word(sgv_pkg::CMD_START, 4'($urandom), rand48(), rand48(), rand48());
         end else if (pick < 18) begin
            if ($urandom_range(0, 3) == 0)
               send_word(sgv_pkg::CMD_LOAD, 4'($urandom), rand48(), rand48(), rand48());
            else
               send_word(sgv_pkg::CMD_LOAD, 4'($urandom), 48'(rand_sym(32'hFFFF_FFFF) * 3),
                         48'(rand_sym(32'h0800_0000)), rand48());
         end else if (pick < 22) begin
            send_word(CMD_UNUSED, 4'($urandom), rand48(), rand48(), rand48());
         end else begin
            ret = ($urandom_range(0, 9) == 0) ? longint'($signed(rand48()))
                                              : rand_sym(32'hFFFF_FFFF) * 2;
            send_word(sgv_pkg::CMD_RETURN, 4'($urandom), rand48(), rand48(), ret[47:0]);
         end
      end
      drain();
   endtask

   initial begin
      init_var_q = ONE_Q;
      omega_q = 0;
      c0_q = 0;
      c1_q = 0;
      c2_q = 0;
      knots_used = 0;
      cur_var = 0;
      series_down = 1'b1;
      foreach (knot_pos[i]) begin
         knot_pos[i] = 0;
         knot_wt[i] = 0;
      end
      req_if.valid <= 1'b0;
      req_if.command <= sgv_pkg::CMD_LOAD;
      req_if.knot_index <= '0;
      req_if.knot_position <= '0;
      req_if.knot_weight <= '0;
      req_if.return_value <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= sgv_pkg::REG_INIT_VAR;
      csr_if.data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_refused_before_start();
      test_knot_table();
      drain();
      test_return_extremes();
      test_failing_series();
      for (int p = 0; p < 6; p++) test_random_series(p == 2 || p == 5, 95);

      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ spline_garch_variance_recursion_unit.f @@
+incdir+design
design/sgv_pkg.sv
design/sgv_ifs.sv
design/sgv_ram.sv
design/sgv_mul.sv
design/sgv_sqdiv.sv
design/spline_garch_variance_recursion_unit.sv
design/sgv_checker.sv
tb/testbench.sv
